>>> src/bilevel_run_length_encoder_unit_assert.svh
// assertion macros for the bilevel run-length encoder
`ifndef BILEVEL_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`define BILEVEL_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define BLRE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");
// checked at every edge, reset included
`define BLRE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("%m: assertion failed");
`else
`define BLRE_ASSERT(label, prop)
`define BLRE_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/blre_pkg.sv
// shared constants and types of the bilevel run-length encoder
`timescale 1ns / 1ps
`default_nettype none
package blre_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 13;
    localparam int HGT_W     = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W     = 30;
    localparam int K_W       = 5;
    localparam int HDR_BITS  = 56;
    localparam int HCNT_W    = 6;

    localparam logic [WID_W-1:0] MAX_WIDTH_W = WID_W'(MAX_WIDTH);
    localparam logic [15:0]      HDR_MAGIC   = 16'hBBAD;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd2;

    typedef struct packed {
        logic [WID_W-1:0] image_width;
        logic [HGT_W-1:0] image_height;
        logic             filter_enable;
    } t_cfg;

    typedef struct packed {
        logic bit_vld;
        logic bit_val;
        logic done;
        logic eoi;
        logic clr;
    } t_pk_req;

    typedef struct packed {
        logic rdy;
        logic empty;
    } t_pk_ack;

endpackage
`default_nettype wire

>>> src/blre_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module blre_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> src/blre_pack.sv
// bit packer: shifts code bits into bytes, holds the newest byte, output register
`timescale 1ns / 1ps
`default_nettype none
`include "bilevel_run_length_encoder_unit_assert.svh"
module blre_pack (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire blre_pkg::t_pk_req i_req,
    output blre_pkg::t_pk_ack     o_ack,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_batch,
    output logic                  o_end_of_image
);
    import blre_pkg::*;

    logic [7:0] r_acc;
    logic [2:0] r_cnt;
    logic [7:0] r_hold;
    logic       r_hold_vld;
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_oeoi;

    logic [7:0] n_acc;
    logic [2:0] n_cnt;
    logic       n_hold_vld;
    logic       n_ovld;

    logic       out_free;
    logic       push_bit;
    logic       do_done;
    logic       complete;
    logic       move;

    always_comb begin
        out_free  = !r_ovld || !i_out_stall;
        o_ack.empty = (r_cnt == 3'd0);
        if (i_req.done) begin
            o_ack.rdy = !r_hold_vld || out_free;
        end else begin
            o_ack.rdy = (r_cnt != 3'd7) || !r_hold_vld || out_free;
        end
        push_bit = i_req.bit_vld && o_ack.rdy;
        do_done  = i_req.done && o_ack.rdy;
        complete = push_bit && (r_cnt == 3'd7);
        move     = r_hold_vld && (complete || do_done);

        n_acc = push_bit ? {r_acc[6:0], i_req.bit_val} : r_acc;
        // a new header drops any partial byte
        if (i_req.clr) begin
            n_cnt = 3'd0;
        end else begin
            n_cnt = push_bit ? r_cnt + 3'd1 : r_cnt;
        end

        n_hold_vld = r_hold_vld;
        if (complete) begin
            n_hold_vld = 1'b1;
        end else if (do_done) begin
            n_hold_vld = 1'b0;
        end

        if (move) begin
            n_ovld = 1'b1;
        end else if (!i_out_stall) begin
            n_ovld = 1'b0;
        end else begin
            n_ovld = r_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_hold_vld <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_hold_vld <= n_hold_vld;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (complete) begin
            r_hold <= n_acc;
        end
        if (move) begin
            r_obyte <= r_hold;
            r_olast <= do_done;
            r_oeoi  <= do_done && i_req.eoi;
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_out_byte      = r_obyte;
    assign o_last_of_batch = r_olast;
    assign o_end_of_image  = r_oeoi;

    `BLRE_ASSERT_ALWAYS(a_eoi_is_last, (r_ovld && r_oeoi) |-> r_olast)
    `BLRE_ASSERT(a_done_flushes_hold, (do_done && r_hold_vld) |=> (r_ovld && r_olast))
    `BLRE_ASSERT(a_out_held_while_stalled, (r_ovld && i_out_stall) |=> (r_ovld && $stable(r_obyte)))

endmodule
`default_nettype wire

>>> src/blre_ctrl.sv
// pixel sequencer: filter, counters, run tracking, header and run-word bit generation
`timescale 1ns / 1ps
`default_nettype none
`include "bilevel_run_length_encoder_unit_assert.svh"
module blre_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire blre_pkg::t_cfg             i_cfg,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_pixel,
    output logic                            o_ram_we,
    output logic [blre_pkg::COL_W-1:0]      o_ram_waddr,
    output logic                            o_ram_wdata,
    output logic                            o_ram_re,
    output logic [blre_pkg::COL_W-1:0]      o_ram_raddr,
    input  wire logic                       i_ram_rdata,
    output blre_pkg::t_pk_req               o_req,
    input  wire blre_pkg::t_pk_ack          i_ack
);
    import blre_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROC   = 3'd1;
    localparam logic [2:0] S_HDR    = 3'd2;
    localparam logic [2:0] S_WSTART = 3'd3;
    localparam logic [2:0] S_WBITS  = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    function automatic logic [RUN_W-1:0] len_m1(input logic [RUN_W-1:0] len);
        return (len == '0) ? '0 : len - RUN_W'(1);
    endfunction

    logic [2:0]          r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [HGT_W-1:0]    r_row, n_row;
    logic                r_raw;
    logic                r_color, n_color;
    logic [RUN_W-1:0]    r_len, n_len;
    logic [RUN_W-1:0]    r_rem, n_rem;
    logic [RUN_W-1:0]    r_lim, n_lim;
    logic [K_W-1:0]      r_k, n_k;
    logic [K_W-1:0]      r_j, n_j;
    logic                r_last_word, n_last_word;
    logic                r_fin, n_fin;
    logic                r_end, n_end;
    logic [HDR_BITS-1:0] r_hdr, n_hdr;
    logic [HCNT_W-1:0]   r_hcnt, n_hcnt;

    logic [WID_W-1:0]    w_eff;
    logic [HGT_W-1:0]    h_eff;
    logic [COL_W-1:0]    col_eff;
    logic                accept;
    logic                pix;
    logic                first;
    logic                last_col;
    logic                last_row;
    logic                img_end;
    logic [RUN_W-1:0]    len_inc;
    logic                do_post;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = WID_W'(1);
        end else if (i_cfg.image_width > MAX_WIDTH_W) begin
            w_eff = MAX_WIDTH_W;
        end else begin
            w_eff = i_cfg.image_width;
        end
        h_eff = (i_cfg.image_height == '0) ? HGT_W'(1) : i_cfg.image_height;
        if (WID_W'(r_col) >= w_eff) begin
            col_eff = COL_W'(w_eff - WID_W'(1));
        end else begin
            col_eff = r_col;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_ram_re    = accept;
    assign o_ram_raddr = col_eff;
    assign o_ram_we    = (r_state == S_PROC);
    assign o_ram_waddr = r_col;
    assign o_ram_wdata = r_raw;

    always_comb begin
        pix      = r_raw ^ (i_cfg.filter_enable && (r_row != '0) && i_ram_rdata);
        first    = (r_col == '0) && (r_row == '0);
        last_col = (WID_W'(r_col) + WID_W'(1)) >= w_eff;
        last_row = ({1'b0, r_row} + (HGT_W + 1)'(1)) >= {1'b0, h_eff};
        img_end  = last_col && last_row;
        len_inc  = r_len + RUN_W'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_color     = r_color;
        n_len       = r_len;
        n_rem       = r_rem;
        n_lim       = r_lim;
        n_k         = r_k;
        n_j         = r_j;
        n_last_word = r_last_word;
        n_fin       = r_fin;
        n_end       = r_end;
        n_hdr       = r_hdr;
        n_hcnt      = r_hcnt;
        o_req       = '0;
        do_post     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_col   = col_eff;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                n_fin = img_end;
                n_end = img_end;
                if (last_col) begin
                    n_col = '0;
                    n_row = last_row ? '0 : r_row + HGT_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
                if (first) begin
                    o_req.clr = 1'b1;
                    n_hdr   = {HDR_MAGIC, 3'b000, w_eff, 1'b0, h_eff, 6'b000000,
                               i_cfg.filter_enable, pix};
                    n_hcnt  = '0;
                    n_color = pix;
                    n_len   = RUN_W'(1);
                    n_state = S_HDR;
                end else if (pix != r_color) begin
                    n_rem   = len_m1(r_len);
                    n_color = pix;
                    n_len   = RUN_W'(1);
                    n_lim   = RUN_W'(1);
                    n_k     = K_W'(1);
                    n_state = S_WSTART;
                end else if (img_end) begin
                    n_rem   = len_m1(len_inc);
                    n_fin   = 1'b0;
                    n_len   = '0;
                    n_color = 1'b0;
                    n_lim   = RUN_W'(1);
                    n_k     = K_W'(1);
                    n_state = S_WSTART;
                end else begin
                    n_len   = len_inc;
                    n_state = S_IDLE;
                end
            end
            S_HDR: begin
                o_req.bit_vld = 1'b1;
                o_req.bit_val = r_hdr[HDR_BITS-1];
                if (i_ack.rdy) begin
                    n_hdr  = {r_hdr[HDR_BITS-2:0], 1'b0};
                    n_hcnt = r_hcnt + HCNT_W'(1);
                    if (r_hcnt == HCNT_W'(HDR_BITS - 1)) begin
                        do_post = 1'b1;
                    end
                end
            end
            S_WSTART: begin
                if (r_rem < r_lim) begin
                    n_last_word = 1'b1;
                end else begin
                    n_rem       = r_rem - r_lim;
                    n_last_word = 1'b0;
                end
                n_j     = r_k - K_W'(1);
                n_state = S_WBITS;
            end
            S_WBITS: begin
                o_req.bit_vld = 1'b1;
                o_req.bit_val = r_last_word ? r_rem[r_j] : 1'b1;
                if (i_ack.rdy) begin
                    if (r_j == '0) begin
                        if (r_last_word) begin
                            do_post = 1'b1;
                        end else begin
                            n_lim   = {r_lim[RUN_W-2:0], 1'b1};
                            n_k     = r_k + K_W'(1);
                            n_state = S_WSTART;
                        end
                    end else begin
                        n_j = r_j - K_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                // zero padding of the last partial byte
                if (i_ack.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_req.bit_vld = 1'b1;
                    o_req.bit_val = 1'b0;
                end
            end
            S_DONE: begin
                o_req.done = 1'b1;
                o_req.eoi  = r_end;
                if (i_ack.rdy) begin
                    n_end   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_post) begin
            if (r_fin) begin
                n_fin   = 1'b0;
                n_rem   = len_m1(r_len);
                n_len   = '0;
                n_color = 1'b0;
                n_lim   = RUN_W'(1);
                n_k     = K_W'(1);
                n_state = S_WSTART;
            end else if (r_end) begin
                n_state = S_FLUSH;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_color <= 1'b0;
            r_len   <= '0;
            r_fin   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
            r_len   <= n_len;
            r_fin   <= n_fin;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_pixel;
        end
        r_rem       <= n_rem;
        r_lim       <= n_lim;
        r_k         <= n_k;
        r_j         <= n_j;
        r_last_word <= n_last_word;
        r_hdr       <= n_hdr;
        r_hcnt      <= n_hcnt;
    end

    `BLRE_ASSERT(a_accept_to_proc, accept |=> (r_state == S_PROC))
    `BLRE_ASSERT(a_bit_index_in_word, (r_state == S_WBITS) |-> (r_j < r_k))
    `BLRE_ASSERT(a_final_word_fits, (r_state == S_WBITS && r_last_word) |-> (r_rem < r_lim))

endmodule
`default_nettype wire

>>> src/bilevel_run_length_encoder_unit.sv
// top level of the bilevel run-length encoder: configuration registers and unit wiring
// a pixel that only extends a run is accepted, then filtered and counted
// a run end adds a start step and k bit steps per k-bit code word, then a close step
// the first pixel of an image adds the 56 header bits, the last adds zero padding
// code bits enter the packer one per cycle while it is ready; done sends the last byte
// synchronous reset clears counters, run state and packer; line store is left as it is
`timescale 1ns / 1ps
`default_nettype none
module bilevel_run_length_encoder_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [blre_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [blre_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_pixel,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [7:0]                            o_out_byte,
    output logic                                  o_last_of_batch,
    output logic                                  o_end_of_image
);
    import blre_pkg::*;

    t_cfg             r_cfg, n_cfg;
    t_pk_req          pk_req;
    t_pk_ack          pk_ack;
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic             ram_re;
    logic [COL_W-1:0] ram_raddr;
    logic             ram_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:   n_cfg.image_width   = i_cfg_data[WID_W-1:0];
                CFG_IMAGE_HEIGHT:  n_cfg.image_height  = i_cfg_data[HGT_W-1:0];
                CFG_FILTER_ENABLE: n_cfg.filter_enable = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= WID_W'(1);
            r_cfg.image_height  <= HGT_W'(1);
            r_cfg.filter_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    blre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_req       (pk_req),
        .i_ack       (pk_ack)
    );

    blre_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    blre_pack u_pack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (pk_req),
        .o_ack           (pk_ack),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_batch (o_last_of_batch),
        .o_end_of_image  (o_end_of_image)
    );

endmodule
`default_nettype wire

>>> bench/bilevel_run_length_encoder_unit_tb.sv
// testbench for the bilevel run-length encoder: directed and random images checked byte by byte
`timescale 1ns / 1ps
`default_nettype none
module bilevel_run_length_encoder_unit_tb;
    import blre_pkg::*;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eoi;
    } t_coded_byte;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_pixel;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_last_of_batch;
    logic                 o_end_of_image;

    bilevel_run_length_encoder_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_batch (o_last_of_batch),
        .o_end_of_image  (o_end_of_image)
    );

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int stuck_cycles   = 0;

    t_coded_byte expected_stream[$];
    t_coded_byte pixel_bytes[$];

    // encoder state as the block should hold it
    logic [WID_W-1:0] reg_width  = 1;
    logic [HGT_W-1:0] reg_height = 1;
    bit               reg_filter = 0;
    bit               line_mem [MAX_WIDTH];
    int unsigned      enc_col    = 0;
    int unsigned      enc_row    = 0;
    int unsigned      enc_run    = 0;
    bit               enc_colour = 0;
    bit [7:0]         enc_acc    = 0;
    int unsigned      enc_bitpos = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void push_byte(bit [7:0] b);
        t_coded_byte c;
        c.data = b;
        c.last = 1'b0;
        c.eoi  = 1'b0;
        pixel_bytes.push_back(c);
    endfunction

    function automatic void push_bits(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) begin
            if (v[i])
                enc_acc |= 8'h80 >> enc_bitpos;
            if (enc_bitpos == 7) begin
                push_byte(enc_acc);
                enc_acc    = '0;
                enc_bitpos = 0;
            end else begin
                enc_bitpos++;
            end
        end
    endfunction

    // length minus one as saturating words of growing width
    function automatic void push_run(int unsigned len);
        int unsigned r;
        int unsigned lim;
        r = (len == 0) ? 0 : len - 1;
        for (int k = 1; k <= RUN_W; k++) begin
            lim = (1 << k) - 1;
            if (r < lim) begin
                push_bits(r, k);
                return;
            end
            push_bits(lim, k);
            r -= lim;
        end
    endfunction

    function automatic void encode_pixel(bit raw);
        int unsigned w;
        int unsigned h;
        bit          p;
        bit          last_col;
        bit          last_row;
        t_coded_byte c;
        w = reg_width;
        h = reg_height;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (enc_col >= w) enc_col = w - 1;
        pixel_bytes.delete();
        p = raw;
        if (reg_filter && enc_row > 0)
            p ^= line_mem[enc_col];
        line_mem[enc_col] = raw;
        last_row = 1'b0;
        if (enc_col == 0 && enc_row == 0) begin
            push_byte(HDR_MAGIC[15:8]);
            push_byte(HDR_MAGIC[7:0]);
            push_byte(w[15:8]);
            push_byte(w[7:0]);
            push_byte(h[15:8]);
            push_byte(h[7:0]);
            push_byte({6'b0, reg_filter, p});
            enc_acc    = '0;
            enc_bitpos = 0;
            enc_colour = p;
            enc_run    = 1;
        end else if (p != enc_colour) begin
            push_run(enc_run);
            enc_colour = p;
            enc_run    = 1;
        end else begin
            enc_run = (enc_run + 1) & 32'h3FFF_FFFF;
        end
        last_col = (enc_col + 1 >= w);
        if (last_col) begin
            enc_col = 0;
            if (enc_row + 1 >= h) begin
                last_row = 1'b1;
                push_run(enc_run);
                if (enc_bitpos != 0)
                    push_byte(enc_acc);
                enc_row    = 0;
                enc_run    = 0;
                enc_colour = 0;
                enc_acc    = '0;
                enc_bitpos = 0;
            end else begin
                enc_row = (enc_row + 1) & 32'h7FFF;
            end
        end else begin
            enc_col = (enc_col + 1) & 32'hFFF;
        end
        if (pixel_bytes.size() != 0) begin
            c = pixel_bytes[pixel_bytes.size() - 1];
            c.last = 1'b1;
            c.eoi  = last_row;
            pixel_bytes[pixel_bytes.size() - 1] = c;
        end
        foreach (pixel_bytes[i])
            expected_stream.push_back(pixel_bytes[i]);
    endfunction

    task automatic send_pixel(bit px);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        encode_pixel(px);
    endtask

    // drop valid, let every expected byte arrive, then let the pipeline drain
    task automatic settle_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stream.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(int unsigned w, int unsigned h, bit f);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        reg_width = WID_W'(w);
        i_cfg_idx  <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        reg_height = HGT_W'(h);
        i_cfg_idx  <= CFG_FILTER_ENABLE;
        i_cfg_data <= CFG_W'(f);
        @(posedge i_clk);
        reg_filter = f;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_coded_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_stream.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %h", $time, o_out_byte);
                fail_count++;
            end else begin
                want = expected_stream.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte: expected %h, actual %h",
                             $time, want.data, o_out_byte);
                    fail_count++;
                end
                if (o_last_of_batch !== want.last) begin
                    $display("%0t: last_of_batch: expected %b, actual %b",
                             $time, want.last, o_last_of_batch);
                    fail_count++;
                end
                if (o_end_of_image !== want.eoi) begin
                    $display("%0t: end_of_image: expected %b, actual %b",
                             $time, want.eoi, o_end_of_image);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("bilevel_run_length_encoder_unit: mismatch");
            $finish;
        end
    end

    // each pixel is a whole 1x1 image at the reset settings
    task automatic test_reset_defaults();
        send_pixel(1'b1);
        send_pixel(1'b0);
        settle_block();
    endtask

    task automatic test_size_extremes();
        apply_cfg(0, 0, 1'b0);
        send_pixel(1'b1);
        settle_block();
        // full width and tallest image, cut short by a narrower width and a height of one in the first row
        apply_cfg(MAX_WIDTH, 32767, 1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        settle_block();
        apply_cfg(2, 1, 1'b1);
        send_pixel(1'b1);
        settle_block();
        // width above the store size clamps in the header
        apply_cfg(8191, 32767, 1'b0);
        send_pixel(1'b0);
        send_pixel(1'b0);
        settle_block();
        apply_cfg(1, 1, 1'b0);
        send_pixel(1'b1);
        settle_block();
    endtask

    task automatic test_row_filter();
        bit [8:0] img_filtered;
        bit [3:0] img_plain;
        img_filtered = 9'b101_110_010;
        img_plain    = 4'b0110;
        apply_cfg(3, 3, 1'b1);
        for (int i = 8; i >= 0; i--)
            send_pixel(img_filtered[i]);
        settle_block();
        apply_cfg(2, 2, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_pixel(img_plain[i]);
        settle_block();
    endtask

    task automatic test_random_stream(int n_items, int send_pct, int recv_pct);
        int          sent;
        int          keep_pct;
        int          pick;
        int unsigned w;
        int unsigned h;
        bit          px;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent     = 0;
        keep_pct = 80;
        px       = 1'b0;
        while (sent < n_items) begin
            if (enc_row == 0 &&
                (enc_col == 0 ? $urandom_range(2) != 0 : $urandom_range(19) == 0)) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    w = $urandom_range(1, 8);
                else if (pick < 88)
                    w = $urandom_range(9, 40);
                else
                    case ($urandom_range(3))
                        0: w = 0;
                        1: w = MAX_WIDTH;
                        2: w = 8191;
                        default: w = $urandom_range(MAX_WIDTH + 1, 8191);
                    endcase
                pick = $urandom_range(99);
                if (pick < 80)
                    h = $urandom_range(1, 4);
                else if (pick < 92)
                    h = $urandom_range(5, 8);
                else
                    case ($urandom_range(2))
                        0: h = 0;
                        1: h = 32767;
                        default: h = $urandom_range(9, 32767);
                    endcase
                settle_block();
                apply_cfg(w, h, 1'($urandom_range(1)));
                keep_pct = $urandom_range(50, 97);
            end else if (enc_row > 0 && $urandom_range(29) == 0) begin
                // shorten the image mid-way; width kept so the line store stays valid
                settle_block();
                apply_cfg(reg_width, 1, reg_filter);
            end
            if ($urandom_range(99) >= keep_pct)
                px = ~px;
            send_pixel(px);
            sent++;
        end
        settle_block();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_pixel    <= 1'b0;
        foreach (line_mem[i])
            line_mem[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct  = 8;
        recv_stall_pct = 79;
        test_reset_defaults();
        test_size_extremes();
        test_row_filter();
        test_random_stream(28, 8, 79);
        test_random_stream(28, 79, 8);
        test_random_stream(28, 0, 0);
        if (fail_count == 0)
            $display("bilevel_run_length_encoder_unit: match");
        else
            $display("bilevel_run_length_encoder_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
